@@ rtl/cdg_pkg.sv @@
// Shared types and constants for the controlled dense gate block.
package cdg_pkg;

  // Complex amplitude or matrix entry, signed Q3.29 parts
  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } cplx_t;

  // Accumulator width: Q6.58 products, up to 128 terms, plus margin
  localparam int AccW = 72;

  // Request codes
  localparam logic [1:0] REQ_WR_AMP = 2'd0;
  localparam logic [1:0] REQ_WR_MAT = 2'd1;
  localparam logic [1:0] REQ_APPLY  = 2'd2;
  localparam logic [1:0] REQ_RD_AMP = 2'd3;

  // Qubit count after reset
  localparam logic [4:0] QubitsReset = 5'd16;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TOO_MANY = 2'd1,
    STATUS_BAD_MASK = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MAC_ADD_RE,
    MAC_SUB_RE,
    MAC_ADD_IM
  } mac_op_e;

  // Control from the sequencer to the complex MAC
  typedef struct packed {
    logic    clr;
    logic    mul_en;
    mac_op_e op;
  } mac_ctrl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_GRD,
    S_GWR,
    S_MRD,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_FIN,
    S_WB,
    S_DONE
  } state_e;

endpackage

@@ rtl/cdg_amp_ram.sv @@
// Amplitude memory: one write port, one registered read port.
module cdg_amp_ram
  import cdg_pkg::*;
#(
  parameter int AW = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  cplx_t         wdata_i,
  input  logic [AW-1:0] raddr_i,
  output cplx_t         rdata_o
);

  cplx_t mem [0:(1<<AW)-1];
  cplx_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/cdg_cmac.sv @@
// Complex multiply-accumulate with round-to-nearest and saturation.
module cdg_cmac
  import cdg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mac_ctrl_t          ctrl_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output cplx_t              res_o,
  output logic               pend_o
);

  localparam int SW = AccW - 29;

  logic signed [63:0]   prod_q;
  mac_op_e              op_q;
  logic                 pend_q;
  logic signed [AccW-1:0] acc_re_q, acc_im_q;
  logic signed [AccW-1:0] prod_ext;

  // product stage
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    op_q   <= ctrl_i.op;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= ctrl_i.mul_en;
    end
  end

  assign prod_ext = AccW'(prod_q);

  // accumulate stage
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (pend_q) begin
      case (op_q)
        MAC_ADD_RE: acc_re_q <= acc_re_q + prod_ext;
        MAC_SUB_RE: acc_re_q <= acc_re_q - prod_ext;
        MAC_ADD_IM: acc_im_q <= acc_im_q + prod_ext;
        default:    acc_im_q <= acc_im_q;
      endcase
    end
  end

  // round half up to Q3.29, then clamp to 32 bits
  function automatic logic signed [31:0] finish(input logic signed [AccW-1:0] acc);
    logic signed [AccW-1:0] t;
    logic signed [SW-1:0]   s;
    t = acc + AccW'(1 << 28);
    s = t[AccW-1:29];
    if (s[SW-1:31] == {(SW-31){s[31]}}) begin
      finish = s[31:0];
    end else if (s[SW-1]) begin
      finish = 32'sh8000_0000;
    end else begin
      finish = 32'sh7FFF_FFFF;
    end
  endfunction

  assign res_o.re = finish(acc_re_q);
  assign res_o.im = finish(acc_im_q);
  assign pend_o   = pend_q;

endmodule

@@ rtl/controlled_dense_gate_apply.sv @@
// A write returns its result via the completion state; a read passes the read state first.
// in_stall_o holds off the next transfer until the current result is loaded into the output register.
// Apply: scans each basis index of 2^n and, per controlled group of 2^k members, gathers the members
//   into the group buffer, then computes each row on the single shared 32x32 multiplier (a matrix
//   read and four products per column) and writes it back; the result goes out via the completion state.
// Reset clears control state and sets qubits_q to 16; amplitude, matrix and group buffer
//   contents are undefined until written, and there is no clearing pass.
module controlled_dense_gate_apply
  import cdg_pkg::*;
#(
  parameter int MAX_QUBITS  = 16,
  parameter int MAX_TARGETS = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [4:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [15:0]        amp_index_i,
  input  logic [2:0]         mat_row_i,
  input  logic [2:0]         mat_col_i,
  input  logic signed [31:0] value_re_i,
  input  logic signed [31:0] value_im_i,
  input  logic [15:0]        tgt_qubits_i,
  input  logic [15:0]        ctrl_qubits_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] amp_re_o,
  output logic signed [31:0] amp_im_o,
  output logic [1:0]         status_o
);

  localparam int AW     = MAX_QUBITS;
  localparam int TW     = MAX_TARGETS;
  localparam int MatDim = 1 << TW;
  localparam int MatAw  = 2 * TW;

  state_e state_q, state_d;
  logic [4:0]    qubits_q;
  logic [4:0]    n_eff;
  logic [AW-1:0] nmask;
  logic [AW-1:0] idx;
  logic [39:0]   idx_ext, tm_ext, cm_ext;
  logic          in_acc;
  logic          too_many, bad_mask;

  logic [AW-1:0] tmask_q, cmask_q, base_q, gsub_q, rsub_q, csub_q;
  logic [TW-1:0] gc_q, rr_q, cc_q;
  logic          base_match, base_last;

  cplx_t   res_q;
  status_e res_status_q;
  logic    out_valid_q, out_load;
  cplx_t   out_q;
  status_e out_status_q;

  logic          amp_we;
  logic [AW-1:0] amp_waddr, amp_raddr;
  cplx_t         amp_wdata, amp_rdata;

  cplx_t          mat_mem [0:MatDim*MatDim-1];
  cplx_t          gbuf_mem [0:MatDim-1];
  cplx_t          mat_rd_q, gbuf_rd_q;
  logic [7:0]     row8, col8;
  logic           mat_we;
  logic [MatAw-1:0] mat_waddr;

  mac_ctrl_t          mac_ctrl;
  logic signed [31:0] mac_a, mac_b;
  cplx_t              mac_res;
  logic               mac_pend;

  // next member of the target subset, ascending
  function automatic logic [AW-1:0] next_sub(input logic [AW-1:0] sub,
                                             input logic [AW-1:0] mask);
    next_sub = ((sub | ~mask) + AW'(1)) & mask;
  endfunction

  // qubit count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qubits_q <= QubitsReset;
    end else if (cfg_we_i) begin
      qubits_q <= cfg_wdata_i;
    end
  end

  // clamped qubit count and index mask
  always_comb begin
    if (qubits_q == 5'd0) begin
      n_eff = 5'd1;
    end else if (qubits_q > 5'(MAX_QUBITS)) begin
      n_eff = 5'(MAX_QUBITS);
    end else begin
      n_eff = qubits_q;
    end
    for (int i = 0; i < AW; i++) begin
      nmask[i] = (5'(i) < n_eff);
    end
  end

  assign idx_ext = 40'(amp_index_i);
  assign tm_ext  = 40'(tgt_qubits_i);
  assign cm_ext  = 40'(ctrl_qubits_i);
  assign idx     = idx_ext[AW-1:0] & nmask;

  // apply mask checks
  always_comb begin
    too_many = ($countones(tgt_qubits_i) > MAX_TARGETS);
    bad_mask = |(tgt_qubits_i & ctrl_qubits_i);
    for (int i = 0; i < 16; i++) begin
      if ((tgt_qubits_i[i] | ctrl_qubits_i[i]) && (5'(i) >= n_eff)) begin
        bad_mask = 1'b1;
      end
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign base_match = ((base_q & (tmask_q | cmask_q)) == cmask_q);
  assign base_last  = (base_q == nmask);
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // sequencer: next state and datapath controls
  always_comb begin
    state_d  = state_q;
    mac_ctrl = '{clr: 1'b0, mul_en: 1'b0, op: MAC_ADD_RE};
    mac_a    = mat_rd_q.re;
    mac_b    = gbuf_rd_q.re;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (req_type_i)
            REQ_RD_AMP: state_d = S_READ;
            REQ_APPLY:  state_d = (too_many || bad_mask) ? S_DONE : S_SCAN;
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_READ: state_d = S_DONE;
      S_SCAN: begin
        if (base_match) begin
          state_d = S_GRD;
        end else if (base_last) begin
          state_d = S_DONE;
        end
      end
      S_GRD: state_d = S_GWR;
      S_GWR: begin
        if (gsub_q == tmask_q) begin
          state_d      = S_MRD;
          mac_ctrl.clr = 1'b1;
        end else begin
          state_d = S_GRD;
        end
      end
      S_MRD: state_d = S_MUL0;
      S_MUL0: begin
        state_d         = S_MUL1;
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.op     = MAC_ADD_RE;
      end
      S_MUL1: begin
        state_d         = S_MUL2;
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.op     = MAC_SUB_RE;
        mac_a           = mat_rd_q.im;
        mac_b           = gbuf_rd_q.im;
      end
      S_MUL2: begin
        state_d         = S_MUL3;
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.op     = MAC_ADD_IM;
        mac_b           = gbuf_rd_q.im;
      end
      S_MUL3: begin
        state_d         = (csub_q == tmask_q) ? S_FIN : S_MRD;
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.op     = MAC_ADD_IM;
        mac_a           = mat_rd_q.im;
      end
      S_FIN: state_d = S_WB;
      S_WB: begin
        mac_ctrl.clr = 1'b1;
        if (rsub_q != tmask_q) begin
          state_d = S_MRD;
        end else if (base_last) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // sweep counters and result staging
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_q        <= '0;
          res_status_q <= STATUS_OK;
          tmask_q      <= tm_ext[AW-1:0];
          cmask_q      <= cm_ext[AW-1:0];
          base_q       <= '0;
          if (req_type_i == REQ_APPLY) begin
            if (too_many) begin
              res_status_q <= STATUS_TOO_MANY;
            end else if (bad_mask) begin
              res_status_q <= STATUS_BAD_MASK;
            end
          end
        end
      end
      S_READ: res_q <= amp_rdata;
      S_SCAN: begin
        gsub_q <= '0;
        gc_q   <= '0;
        if (!base_match) begin
          base_q <= base_q + AW'(1);
        end
      end
      S_GWR: begin
        gsub_q <= next_sub(gsub_q, tmask_q);
        gc_q   <= gc_q + TW'(1);
        rsub_q <= '0;
        rr_q   <= '0;
        csub_q <= '0;
        cc_q   <= '0;
      end
      S_MUL3: begin
        csub_q <= next_sub(csub_q, tmask_q);
        cc_q   <= cc_q + TW'(1);
      end
      S_WB: begin
        rsub_q <= next_sub(rsub_q, tmask_q);
        rr_q   <= rr_q + TW'(1);
        csub_q <= '0;
        cc_q   <= '0;
        if (rsub_q == tmask_q) begin
          base_q <= base_q + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // amplitude memory ports
  assign amp_we    = (in_acc && (req_type_i == REQ_WR_AMP)) || (state_q == S_WB);
  assign amp_waddr = (state_q == S_IDLE) ? idx : (base_q | rsub_q);
  assign amp_wdata = (state_q == S_IDLE) ? cplx_t'{re: value_re_i, im: value_im_i} : mac_res;
  assign amp_raddr = (state_q == S_IDLE) ? idx : (base_q | gsub_q);

  cdg_amp_ram #(
    .AW(AW)
  ) u_amp_ram (
    .clk_i  (clk_i),
    .we_i   (amp_we),
    .waddr_i(amp_waddr),
    .wdata_i(amp_wdata),
    .raddr_i(amp_raddr),
    .rdata_o(amp_rdata)
  );

  // gate matrix store
  assign row8      = 8'(mat_row_i);
  assign col8      = 8'(mat_col_i);
  assign mat_we    = in_acc && (req_type_i == REQ_WR_MAT) &&
                     (row8 < 8'(MatDim)) && (col8 < 8'(MatDim));
  assign mat_waddr = {row8[TW-1:0], col8[TW-1:0]};

  always_ff @(posedge clk_i) begin
    if (mat_we) begin
      mat_mem[mat_waddr] <= cplx_t'{re: value_re_i, im: value_im_i};
    end
    mat_rd_q <= mat_mem[{rr_q, cc_q}];
  end

  // group buffer
  always_ff @(posedge clk_i) begin
    if (state_q == S_GWR) begin
      gbuf_mem[gc_q] <= amp_rdata;
    end
    gbuf_rd_q <= gbuf_mem[cc_q];
  end

  cdg_cmac u_cmac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(mac_ctrl),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .res_o (mac_res),
    .pend_o(mac_pend)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q        <= res_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign amp_re_o    = out_q.re;
  assign amp_im_o    = out_q.im;
  assign status_o    = out_status_q;

  // write-back only after the last product is accumulated
  a_wb_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WB |-> !mac_pend)
    else $error("write-back with product still in flight");

  // gather offsets stay inside the target mask
  a_gsub_in_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GRD || state_q == S_GWR) |-> ((gsub_q & ~tmask_q) == '0))
    else $error("gather offset outside target mask");

  // a sweep only runs on disjoint masks
  a_sweep_masks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> ((tmask_q & cmask_q) == '0))
    else $error("sweep with overlapping masks");

  // a new result comes only from the completion state
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result without completion");

endmodule
